/* rtl/lebrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lebrt_pkg
// Shared types and constants of the longest equal bit run tracker.
// ----------------------------------------------------------------------------
package lebrt_pkg;

   localparam int unsigned MaxBitsDefault = 1024;
   localparam int unsigned LenWidth       = 11;
   localparam int unsigned IdxWidth       = 10;
   localparam int unsigned RunMax         = 2047;
   localparam logic [LenWidth-1:0] LenReset = 11'd1024;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_FLIP = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEAF,
      ST_CLIMB,
      ST_QUERY
   } state_type;

endpackage : lebrt_pkg
`default_nettype wire

/* rtl/lebrt_tree_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lebrt_tree_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lebrt_tree_ram #(
   parameter int unsigned AW = 11,
   parameter int unsigned DW = 35
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule : lebrt_tree_ram
`default_nettype wire

/* rtl/longest_equal_bit_run_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_equal_bit_run_tracker_unit
// Bit vector with load/flip updates; reports the longest run of equal bits.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: a word is taken when start is high and busy is low. A load
//    writes req_bit_value at req_bit_index, a flip inverts that bit.
//  - rsp_ channel: one word per request, shown for a single cycle with
//    rsp_valid high; the receiver cannot stall it.
//  - csr_ channel: used_length write, always ready; write only while idle.
// The vector lives in a segment tree (prefix, suffix, best run and end bits
// per node) in one RAM of 2*P entries, P = MAX_BITS rounded up to a power of
// two, LV = log2(P). An update reads the leaf, writes it, then climbs LV
// levels at one RAM read per level; the answer is then gathered over the
// prefix nodes of used_length, one read per cycle. The result strobe
// rises in the cycle in which busy drops, so a new request can be taken
// while the strobe is high, but not before; an out-of-range index skips
// the leaf write and the climb.
// Reset clears control state and then sweeps tree RAM addresses 1 to
// 2*P-1 to the all-zero vector; busy is high during the sweep.
// ----------------------------------------------------------------------------
module longest_equal_bit_run_tracker_unit #(
   parameter int unsigned MAX_BITS = lebrt_pkg::MaxBitsDefault
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_op,
   input  wire logic [lebrt_pkg::IdxWidth-1:0]   req_bit_index,
   input  wire logic                             req_bit_value,
   output logic                                  rsp_valid,
   output logic      [lebrt_pkg::LenWidth-1:0]   rsp_longest_run,
   output logic                                  rsp_index_error,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lebrt_pkg::LenWidth-1:0]   csr_data
);
   import lebrt_pkg::*;

   localparam int unsigned LV = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
   localparam int unsigned P  = 2**LV;
   localparam int unsigned RW = LV + 1;
   localparam int unsigned AW = LV + 1;
   localparam int unsigned NW = 3*RW + 2;
   localparam int unsigned KW = $clog2(LV + 2);

   // node fields
   localparam int unsigned LB = NW - 1;
   localparam int unsigned RB = NW - 2;

   function automatic logic [NW-1:0] mk_node(input logic lb, input logic rb,
         input logic [RW-1:0] pre, input logic [RW-1:0] suf,
         input logic [RW-1:0] best);
      mk_node = {lb, rb, pre, suf, best};
   endfunction

   function automatic logic [NW-1:0] join_f(input logic [NW-1:0] a,
         input logic [NW-1:0] b, input logic [RW-1:0] la,
         input logic [RW-1:0] lb);
      logic          jn;
      logic [RW-1:0] ap, as, ab, bp, bs, bb, pre, suf, best, mid;
      ap = a[3*RW-1:2*RW]; as = a[2*RW-1:RW]; ab = a[RW-1:0];
      bp = b[3*RW-1:2*RW]; bs = b[2*RW-1:RW]; bb = b[RW-1:0];
      jn  = (a[RB] == b[LB]);
      pre = (jn && ap == la) ? la + bp : ap;
      suf = (jn && bs == lb) ? lb + as : bs;
      mid = jn ? as + bp : '0;
      best = (ab > bb) ? ab : bb;
      if (mid > best) best = mid;
      join_f = mk_node(a[LB], b[RB], pre, suf, best);
   endfunction

   state_type state_ff, state_in;

   logic [LenWidth-1:0] used_len_ff, used_len_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [RW-1:0]       size_ff, size_in;
   logic [NW-1:0]       node_ff, node_in;
   logic                op_ff, op_in, val_ff, val_in, err_ff, err_in;
   logic [RW-1:0]       n_ff, n_in;
   logic [RW-1:0]       off_ff, off_in;
   logic [KW-1:0]       qk_ff, qk_in;
   logic                pend_ff, pend_in, empty_ff, empty_in;
   logic [RW-1:0]       psize_ff, psize_in;
   logic [NW-1:0]       acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_err_ff, rsp_err_in;
   logic [LenWidth-1:0] rsp_run_ff, rsp_run_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr, nxt_addr;
   logic [NW-1:0] wr_data, rd_data, leaf, acc_nx;
   logic [RW-1:0] n_eff, n_sh, kk, sz;
   logic          new_bit;

   lebrt_tree_ram #(.AW(AW), .DW(NW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         used_len_ff  <= LenReset;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= AW'(1);
         size_ff      <= RW'(P);
      end else begin
         state_ff     <= state_in;
         used_len_ff  <= used_len_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         size_ff      <= size_in;
      end
      node_ff  <= node_in;
      op_ff    <= op_in;
      val_ff   <= val_in;
      err_ff   <= err_in;
      n_ff     <= n_in;
      off_ff   <= off_in;
      qk_ff    <= qk_in;
      pend_ff  <= pend_in;
      empty_ff <= empty_in;
      psize_ff <= psize_in;
      acc_ff   <= acc_in;
      rsp_err_ff <= rsp_err_in;
      rsp_run_ff <= rsp_run_in;
   end

   // effective length clamped to 1..MAX_BITS
   always_comb begin
      if (used_len_ff == '0) begin
         n_eff = RW'(1);
      end else if (32'(used_len_ff) > MAX_BITS) begin
         n_eff = RW'(MAX_BITS);
      end else begin
         n_eff = RW'(used_len_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      used_len_in  = used_len_ff;
      cur_in       = cur_ff;
      size_in      = size_ff;
      node_in      = node_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      err_in       = err_ff;
      n_in         = n_ff;
      off_in       = off_ff;
      qk_in        = qk_ff;
      pend_in      = pend_ff;
      empty_in     = empty_ff;
      psize_in     = psize_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_err_in   = rsp_err_ff;
      rsp_run_in   = rsp_run_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = node_ff;
      rd_addr      = cur_ff;
      nxt_addr     = cur_ff + AW'(1);
      new_bit      = (op_ff == OP_FLIP) ? ~rd_data[LB] : val_ff;
      leaf         = mk_node(new_bit, new_bit, RW'(1), RW'(1), RW'(1));
      acc_nx       = acc_ff;
      kk           = RW'(qk_ff) - RW'(1);
      n_sh         = n_ff >> kk;
      sz           = RW'(1) << kk;

      if (csr_valid) begin
         used_len_in = csr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = mk_node(1'b0, 1'b0, size_ff, size_ff, size_ff);
            cur_in  = nxt_addr;
            // a new tree level starts at every power of two
            if ((nxt_addr & (nxt_addr - AW'(1))) == '0) begin
               size_in = size_ff >> 1;
            end
            if (cur_ff == AW'(2*P - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               val_in   = req_bit_value;
               n_in     = n_eff;
               err_in   = (32'(req_bit_index) >= 32'(n_eff));
               cur_in   = AW'(32'(P) + 32'(req_bit_index));
               rd_addr  = AW'(32'(P) + 32'(req_bit_index));
               qk_in    = KW'(LV + 1);
               pend_in  = 1'b0;
               empty_in = 1'b1;
               off_in   = '0;
               state_in = (32'(req_bit_index) >= 32'(n_eff)) ? ST_QUERY : ST_LEAF;
            end
         end
         ST_LEAF: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = leaf;
            node_in  = leaf;
            size_in  = RW'(1);
            rd_addr  = cur_ff ^ AW'(1);
            state_in = ST_CLIMB;
         end
         ST_CLIMB: begin
            // rd_data holds the sibling of cur
            node_in = cur_ff[0] ? join_f(rd_data, node_ff, size_ff, size_ff)
                                : join_f(node_ff, rd_data, size_ff, size_ff);
            wr_en   = 1'b1;
            wr_addr = cur_ff >> 1;
            wr_data = node_in;
            cur_in  = cur_ff >> 1;
            size_in = size_ff << 1;
            rd_addr = (cur_ff >> 1) ^ AW'(1);
            if ((cur_ff >> 1) == AW'(1)) begin
               state_in = ST_QUERY;
            end
         end
         ST_QUERY: begin
            // fold the node read last cycle into the prefix accumulator
            if (pend_ff) begin
               acc_nx = empty_ff ? rd_data
                                 : join_f(acc_ff, rd_data, off_ff - psize_ff, psize_ff);
            end
            acc_in   = acc_nx;
            empty_in = empty_ff & ~pend_ff;
            pend_in  = 1'b0;
            rd_addr  = AW'((32'(P) + 32'(off_ff)) >> kk);
            if (qk_ff != '0) begin
               qk_in = qk_ff - KW'(1);
               if (n_sh[0]) begin
                  pend_in  = 1'b1;
                  off_in   = off_ff + sz;
                  psize_in = sz;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_run_in   = (32'(acc_nx[RW-1:0]) > RunMax) ? LenWidth'(RunMax)
                                                           : LenWidth'(acc_nx[RW-1:0]);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = rsp_run_ff;
   assign rsp_index_error = rsp_err_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_longest_run != '0))
      else $error("reported run length is zero");

   a_strobe_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_QUERY))
      else $error("result strobe outside the query phase");

endmodule : longest_equal_bit_run_tracker_unit
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the longest equal bit run tracker.
// Loads and flips go through a burst/gap driver; every response word is
// checked against a bit-vector model that rescans the in-use range. The
// used_length register is swept through several values, extremes included.
// ----------------------------------------------------------------------------
module tb;
   import lebrt_pkg::*;

   typedef struct packed {
      logic                op;
      logic [IdxWidth-1:0] idx;
      logic                val;
   } bit_cmd_type;

   typedef struct packed {
      logic [LenWidth-1:0] run;
      logic                err;
   } run_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = 1'b0;
   logic [IdxWidth-1:0] req_bit_index = '0;
   logic req_bit_value = 1'b0;
   logic rsp_valid;
   logic [LenWidth-1:0] rsp_longest_run;
   logic rsp_index_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LenWidth-1:0] csr_data = '0;

   bit_cmd_type  cmd_queue[$];
   run_word_type run_expect_q[$];
   logic [MaxBitsDefault-1:0] shadow_bits;
   logic [LenWidth-1:0] shadow_len;
   int gap_left = 0;
   int burst_left = 0;
   int fail_count = 0;
   int accepted = 0;

   longest_equal_bit_run_tracker_unit dut (.*);

   always #2 clock = ~clock;

   function automatic int eff_length(logic [LenWidth-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MaxBitsDefault) return MaxBitsDefault;
      return int'(raw);
   endfunction

   // Apply one command to the shadow vector and return the expected word.
   function automatic run_word_type apply_bit_cmd(bit_cmd_type c);
      run_word_type w;
      int n, best, cur;
      n = eff_length(shadow_len);
      w.err = (c.idx >= n);
      if (!w.err) begin
         if (c.op == OP_LOAD) shadow_bits[c.idx] = c.val;
         else shadow_bits[c.idx] = ~shadow_bits[c.idx];
      end
      best = 1;
      cur = 1;
      for (int i = 1; i < n; i++) begin
         cur = (shadow_bits[i] == shadow_bits[i-1]) ? cur + 1 : 1;
         if (cur > best) best = cur;
      end
      if (best > RunMax) best = RunMax;
      w.run = best[LenWidth-1:0];
      return w;
   endfunction

   // Driver: bursts of random length with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the word until taken
      end else begin
         if (start) begin
            run_expect_q.push_back(apply_bit_cmd({req_op, req_bit_index, req_bit_value}));
            accepted++;
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            bit_cmd_type c;
            c = cmd_queue.pop_front();
            req_op <= c.op;
            req_bit_index <= c.idx;
            req_bit_value <= c.val;
            start <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 8);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: one word per response strobe.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (run_expect_q.size() == 0) begin
            $error("unexpected response word");
            fail_count++;
         end else begin
            run_word_type e;
            e = run_expect_q.pop_front();
            if (rsp_longest_run !== e.run) begin
               $error("longest_run exp %0d got %0d", e.run, rsp_longest_run);
               fail_count++;
            end
            if (rsp_index_error !== e.err) begin
               $error("index_error exp %0d got %0d", e.err, rsp_index_error);
               fail_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (cmd_queue.size() > 0 || start || run_expect_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_length(logic [LenWidth-1:0] v);
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_len = v;
   endtask

   function automatic bit_cmd_type rand_cmd(int n);
      bit_cmd_type c;
      c.op = 1'($urandom_range(0, 1));
      c.val = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 15) == 0) c.idx = IdxWidth'($urandom);
      else c.idx = IdxWidth'($urandom_range(0, n - 1));
      return c;
   endfunction

   initial begin
      logic [LenWidth-1:0] lens[8];
      int n;
      lens = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd2, 11'd17, 11'd1025, 11'd300};
      shadow_bits = '0;
      shadow_len = LenReset;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes of index and value, both ops
      cmd_queue.push_back('{OP_LOAD, 10'd0, 1'b1});
      cmd_queue.push_back('{OP_LOAD, 10'd1023, 1'b1});
      cmd_queue.push_back('{OP_FLIP, 10'd1023, 1'b1});
      cmd_queue.push_back('{OP_FLIP, 10'd0, 1'b0});
      cmd_queue.push_back('{OP_LOAD, 10'd512, 1'b1});
      cmd_queue.push_back('{OP_LOAD, 10'd511, 1'b1});
      cmd_queue.push_back('{OP_LOAD, 10'd512, 1'b0});
      cmd_queue.push_back('{OP_FLIP, 10'd511, 1'b0});
      for (int i = 0; i < 10; i++) cmd_queue.push_back('{OP_FLIP, 10'(1 << i), 1'b0});
      wait_drained();
      foreach (lens[k]) begin
         write_length(lens[k]);
         n = eff_length(lens[k]);
         cmd_queue.push_back('{OP_LOAD, 10'(n - 1), 1'b1});
         cmd_queue.push_back('{OP_FLIP, 10'(n < 1024 ? n : 1023), 1'b0});
         cmd_queue.push_back('{OP_LOAD, 10'd1023, 1'b0});
         for (int i = 0; i < 120; i++) cmd_queue.push_back(rand_cmd(n));
         wait_drained();
      end
      repeat (60) @(posedge clock);
      if (fail_count == 0 && run_expect_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule

/* sim.f */
rtl/lebrt_pkg.sv
rtl/lebrt_tree_ram.sv
rtl/longest_equal_bit_run_tracker_unit.sv
bench/tb.sv
